@@ hw/rtl/alm_pkg.sv @@
// Shared types, codes and constants of the audio block level meter.
package alm_pkg;

    // Defaults and fixed codes
    localparam int BLOCK_MAX_DEFAULT = 256;
    localparam logic [15:0] LOW_THR_RESET  = 16'd100;
    localparam logic [15:0] HIGH_THR_RESET = 16'd1000;
    localparam logic [7:0]  CMD_START = 8'h52;  // 'R'
    localparam logic [7:0]  CMD_STOP  = 8'h53;  // 'S'
    localparam logic        CFG_LOW_THR  = 1'b0;
    localparam logic        CFG_HIGH_THR = 1'b1;
    localparam logic        MODE_SAMPLE  = 1'b0;
    localparam logic        MODE_COMMAND = 1'b1;

    localparam logic [2:0] COLOUR_OFF   = 3'd0;
    localparam logic [2:0] COLOUR_DIM   = 3'd1;
    localparam logic [2:0] COLOUR_GREEN = 3'd2;
    localparam logic [2:0] COLOUR_AMBER = 3'd3;
    localparam logic [2:0] COLOUR_RED   = 3'd4;

    typedef enum logic [1:0] {
        KIND_PCM    = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_START  = 2'd2,
        KIND_STOP   = 2'd3
    } t_kind;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] sample_word;
        logic               block_last;
        logic [7:0]         command_byte;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        logic signed [15:0] pcm_sample;
        logic [15:0]        average_level;
        logic [2:0]         colour_class;
    } t_out_item;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

@@ hw/rtl/alm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the block average.
module alm_div
    import alm_pkg::*;
#(
    parameter int SUM_W = 24,
    parameter int CNT_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_div_status      o_status,
    output logic [15:0]      o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;   // dividend shifts out, quotient shifts in
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [CNT_W-1:0]  n_rem;

    // Shared subtract and compare
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= {r_quo[SUM_W-2:0], ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status   = '{busy: r_busy, done: r_done};
    // Average never exceeds 32768, so the low 16 bits hold it
    assign o_quotient = r_quo[15:0];

endmodule

@@ hw/rtl/audio_block_level_meter_unit.sv @@
// Top level of the audio block level meter: sequencer, accumulator, output register.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries either a microphone
// word (mode 0) or a host command byte (mode 1). A transfer happens at a clock edge
// with valid high and stall low. Output channel (o_out_valid / i_out_stall /
// o_out_data) carries PCM samples, level reports and start/stop acknowledges.
// Thresholds are written through i_cfg_we / i_cfg_index / i_cfg_data.
//
// Each result is registered in the pending register and then loaded into the output
// register. A sample that closes a block in monitor mode also runs the restoring
// divider, one quotient bit per cycle over the sum width (24 bits at BLOCK_MAX
// 256), before its report is pending. The input is stalled while an item is in
// work; the next item is taken the cycle after the result is loaded.
//
// Reset (synchronous, active low) selects monitor mode, clears the sum and count
// and loads the default thresholds. While the receiver stalls, the result is held
// in the output register and the next item may still be taken and processed; its
// result waits until the register frees.
module audio_block_level_meter_unit
    import alm_pkg::*;
#(
    parameter int BLOCK_MAX = BLOCK_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CNT_W = $clog2(BLOCK_MAX + 1);
    localparam int SUM_W = CNT_W + 15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic             r_stream, n_stream;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_low_thr, r_high_thr;
    t_out_item        r_pend, n_pend;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             in_xfer;
    logic             out_free;
    logic [15:0]      pcm;
    logic [15:0]      mag;
    logic [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0] acc_cnt;
    logic             closes;
    logic             div_start;
    t_div_status      div_stat;
    logic [15:0]      avg;
    logic [2:0]       colour;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Sample magnitude and accumulator update
    always_comb begin
        pcm     = i_in_data.sample_word[31:16];
        mag     = pcm[15] ? (~pcm + 16'd1) : pcm;
        acc_sum = r_sum + SUM_W'(mag);
        acc_cnt = r_cnt + 1'b1;
        closes  = i_in_data.block_last || (acc_cnt >= CNT_W'(BLOCK_MAX));
    end

    // Colour class of the finished average
    always_comb begin
        priority if (avg > r_low_thr && avg <= r_high_thr) begin
            colour = COLOUR_GREEN;
        end else if (avg > r_high_thr) begin
            colour = COLOUR_AMBER;
        end else if (avg != 16'd0) begin
            colour = COLOUR_DIM;
        end else begin
            colour = COLOUR_OFF;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_stream    = r_stream;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.mode == MODE_COMMAND) begin
                        if (i_in_data.command_byte == CMD_START) begin
                            n_stream = 1'b1;
                            n_pend   = '{KIND_START, 16'sd0, 16'd0, COLOUR_RED};
                            n_state  = ST_EMIT;
                        end else if (i_in_data.command_byte == CMD_STOP) begin
                            n_stream = 1'b0;
                            n_pend   = '{KIND_STOP, 16'sd0, 16'd0, COLOUR_DIM};
                            n_state  = ST_EMIT;
                        end
                    end else begin
                        n_sum = closes ? '0 : acc_sum;
                        n_cnt = closes ? '0 : acc_cnt;
                        if (r_stream) begin
                            n_pend  = '{KIND_PCM, pcm, 16'd0, COLOUR_OFF};
                            n_state = ST_EMIT;
                        end else if (closes) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_pend  = '{KIND_REPORT, 16'sd0, avg, colour};
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_stream    <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_low_thr   <= LOW_THR_RESET;
            r_high_thr  <= HIGH_THR_RESET;
        end else begin
            r_state     <= n_state;
            r_stream    <= n_stream;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LOW_THR:  r_low_thr  <= i_cfg_data;
                    CFG_HIGH_THR: r_high_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    alm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_sum),
        .i_divisor  (acc_cnt),
        .o_status   (div_stat),
        .o_quotient (avg)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // Count at rest never reaches the block limit
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(BLOCK_MAX))
        else $error("sample count reached block limit at rest");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

    // A report never exceeds full scale
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind == KIND_REPORT)
        |-> (o_out_data.average_level <= 16'd32768))
        else $error("average level above full scale");

    // Only PCM results carry a sample
    a_pcm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.result_kind != KIND_PCM)
        |-> (o_out_data.pcm_sample == 16'sd0))
        else $error("non-PCM result carries a sample");
`endif

endmodule

@@ verif/tb_audio_block_level_meter_unit.sv @@
// Self-checking testbench for the audio block level meter: directed and random traffic.
`timescale 1ns / 100ps

module tb_audio_block_level_meter_unit;
    import alm_pkg::*;

    localparam int METER_BLOCK   = BLOCK_MAX_DEFAULT;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 130;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_LOW_THR;
    logic [15:0] i_cfg_data = '0;

    // Meter state as predicted by the testbench
    logic        stream_on;
    logic [23:0] mag_sum;
    int unsigned blk_count;
    logic [15:0] low_thr;
    logic [15:0] high_thr;
    t_out_item   meter_results[$];
    t_out_item   oldest_result;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    bit          no_backpressure = 1'b0;
    bit          no_gaps = 1'b0;

    always #5 i_clk = ~i_clk;

    audio_block_level_meter_unit #(
        .BLOCK_MAX(METER_BLOCK)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Colour class of a level report; tests applied in this order
    function automatic logic [2:0] level_colour(logic [16:0] avg);
        if (avg > low_thr && avg <= high_thr) return COLOUR_GREEN;
        if (avg > high_thr) return COLOUR_AMBER;
        if (avg > 0 && avg <= low_thr) return COLOUR_DIM;
        return COLOUR_OFF;
    endfunction

    // Advance the meter state by one item and queue any result it causes
    function automatic void meter_step(t_in_item it);
        t_out_item   r;
        logic [15:0] pcm;
        logic [16:0] mag;
        logic [16:0] avg;
        bit          closes;
        r = '0;
        if (it.mode == MODE_COMMAND) begin
            if (it.command_byte == CMD_START) begin
                stream_on = 1'b1;
                r.result_kind = KIND_START;
                r.colour_class = COLOUR_RED;
                meter_results.push_back(r);
            end else if (it.command_byte == CMD_STOP) begin
                stream_on = 1'b0;
                r.result_kind = KIND_STOP;
                r.colour_class = COLOUR_DIM;
                meter_results.push_back(r);
            end
            return;
        end
        pcm = it.sample_word[31:16];
        // -32768 has magnitude 32768, hence 17 bits
        mag = pcm[15] ? (17'h10000 - {1'b0, pcm}) : {1'b0, pcm};
        mag_sum += 24'(mag);
        blk_count++;
        closes = it.block_last || (blk_count >= METER_BLOCK);
        if (closes) begin
            avg = 17'(mag_sum / blk_count);
            mag_sum = '0;
            blk_count = 0;
            if (!stream_on) begin
                r.result_kind = KIND_REPORT;
                r.average_level = avg[15:0];
                r.colour_class = level_colour(avg);
                meter_results.push_back(r);
            end
        end
        if (stream_on) begin
            r.result_kind = KIND_PCM;
            r.pcm_sample = pcm;
            meter_results.push_back(r);
        end
    endfunction

    // Result checker: each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (meter_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result kind=%0d pcm=%0d avg=%0d colour=%0d",
                         $time, o_out_data.result_kind, o_out_data.pcm_sample,
                         o_out_data.average_level, o_out_data.colour_class);
            end else begin
                oldest_result = meter_results.pop_front();
                if (o_out_data.result_kind !== oldest_result.result_kind
                    || o_out_data.pcm_sample !== oldest_result.pcm_sample
                    || o_out_data.average_level !== oldest_result.average_level
                    || o_out_data.colour_class !== oldest_result.colour_class) begin
                    mismatch_count++;
                    $display("%0t: mismatch expected kind=%0d pcm=%0d avg=%0d colour=%0d",
                             $time, oldest_result.result_kind, oldest_result.pcm_sample,
                             oldest_result.average_level, oldest_result.colour_class);
                    $display("%0t:          actual   kind=%0d pcm=%0d avg=%0d colour=%0d",
                             $time, o_out_data.result_kind, o_out_data.pcm_sample,
                             o_out_data.average_level, o_out_data.colour_class);
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        i_out_stall <= !no_backpressure && ($urandom_range(0, 99) < 16);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, meter_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input t_in_item it);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 16) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        meter_step(it);
        items_sent++;
    endtask

    task automatic send_sample(input logic [31:0] word, input logic last);
        t_in_item it;
        it.mode = MODE_SAMPLE;
        it.sample_word = word;
        it.block_last = last;
        it.command_byte = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_command(input logic [7:0] cmd);
        t_in_item it;
        it.mode = MODE_COMMAND;
        it.sample_word = $urandom;
        it.block_last = 1'($urandom);
        it.command_byte = cmd;
        send_item(it);
    endtask

    // Microphone word with the given sample on top and random low bits
    function automatic logic [31:0] level_word(logic [15:0] pcm);
        return {pcm, 16'($urandom)};
    endfunction

    function automatic logic [15:0] random_level();
        return 16'($urandom_range(0, 32768) >> $urandom_range(0, 15));
    endfunction

    // Drain all results and let any silent item finish before touching registers
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (meter_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, with write enable dropped again before the next one
    task automatic write_threshold(input logic idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LOW_THR) low_thr = val;
        else high_thr = val;
        @(posedge i_clk);
    endtask

    // Single-sample blocks around the default thresholds
    task automatic test_reset_thresholds();
        send_sample(level_word(16'd0), 1'b1);
        send_sample(level_word(16'd100), 1'b1);
        send_sample(level_word(16'd101), 1'b1);
        send_sample(level_word(16'd1000), 1'b1);
        send_sample(level_word(16'd1001), 1'b1);
        send_sample(level_word(16'hFFFF), 1'b1);
    endtask

    // Full-scale words, most negative sample, truncating division
    task automatic test_sample_extremes();
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_0000, 1'b1);
        send_sample(level_word(16'h0001), 1'b0);
        send_sample(level_word(16'hFFFF), 1'b0);
        send_sample(level_word(16'h0002), 1'b1);
        send_sample(32'h0000_FFFF, 1'b1);
    endtask

    // Start/stop, repeats, ignored bytes, mode change inside a block
    task automatic test_commands();
        send_command(CMD_START);
        send_command(CMD_START);
        send_sample(level_word(16'h1234), 1'b0);
        send_sample(32'hFFFF_0000, 1'b1);
        send_command(CMD_STOP);
        send_command(CMD_STOP);
        send_command(8'h00);
        send_command(8'hFF);
        send_command(8'h72);
        send_sample(level_word(16'd200), 1'b0);
        send_command(CMD_START);
        send_sample(level_word(16'hFF38), 1'b0);
        send_command(CMD_STOP);
        send_sample(level_word(16'd500), 1'b1);
    endtask

    // Thresholds at zero and at full scale, including low above high
    task automatic test_threshold_extremes();
        settle_idle();
        write_threshold(CFG_LOW_THR, 16'd0);
        write_threshold(CFG_HIGH_THR, 16'd0);
        send_sample(level_word(16'd0), 1'b1);
        send_sample(level_word(16'd1), 1'b1);
        settle_idle();
        write_threshold(CFG_LOW_THR, 16'd32768);
        write_threshold(CFG_HIGH_THR, 16'd32768);
        send_sample(level_word(16'h8000), 1'b1);
        send_sample(level_word(16'h7FFF), 1'b1);
        settle_idle();
        write_threshold(CFG_HIGH_THR, 16'd0);
        send_sample(level_word(16'd5), 1'b1);
        send_sample(level_word(16'd0), 1'b1);
        settle_idle();
        write_threshold(CFG_LOW_THR, 16'd0);
        write_threshold(CFG_HIGH_THR, 16'd32768);
        send_sample(level_word(16'h8000), 1'b1);
    endtask

    // Blocks that run past the maximum length, in both modes
    task automatic test_overlong_block();
        int i;
        for (i = 0; i < 300; i++) send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b1);
        send_command(CMD_START);
        for (i = 0; i < 260; i++) send_sample($urandom, 1'b0);
        send_command(CMD_STOP);
        send_sample($urandom, 1'b1);
    endtask

    task automatic send_random_command();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) send_command(CMD_START);
        else if (pick < 8) send_command(CMD_STOP);
        else send_command(8'($urandom));
    endtask

    // One block of samples at a random loudness, with stray commands mixed in
    task automatic send_random_block();
        int pick;
        int len;
        int shift;
        int i;
        logic signed [15:0] pcm;
        pick = $urandom_range(0, 99);
        if (pick < 85) len = $urandom_range(1, 12);
        else if (pick < 97) len = $urandom_range(13, 64);
        else len = $urandom_range(200, 300);
        shift = $urandom_range(0, 15);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) send_random_command();
            if ($urandom_range(0, 49) == 0) pcm = 16'sh8000;
            else pcm = $signed(16'($urandom)) >>> shift;
            send_sample(level_word(pcm), i == len - 1);
        end
    endtask

    // Random phases, each with its own thresholds; one phase runs without idling or backpressure
    task automatic test_random_traffic();
        int phase;
        int unsigned phase_start;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_idle();
            write_threshold(CFG_LOW_THR, random_level());
            write_threshold(CFG_HIGH_THR, random_level());
            no_backpressure = (phase == 4);
            no_gaps = (phase == 4);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_random_block();
        end
        no_backpressure = 1'b0;
        no_gaps = 1'b0;
    endtask

    initial begin
        stream_on = 1'b0;
        mag_sum = '0;
        blk_count = 0;
        low_thr = LOW_THR_RESET;
        high_thr = HIGH_THR_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_thresholds();
        test_sample_extremes();
        test_commands();
        test_threshold_extremes();
        test_overlong_block();
        test_random_traffic();

        // Drain and let the block go quiet
        i_in_valid <= 1'b0;
        while (meter_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && meter_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
